[hw/rtl/sjd_pkg.sv]
// sjd_pkg: shared types and constants for the stillness jolt detector
// holds reset values, register indexes, controller states and the
// command/status structs between controller and datapath; no dependencies
package sjd_pkg;

  // default parameter values
  localparam int unsigned MAX_WINDOW_DEF = 256;
  localparam int unsigned RATE_NUM_DEF   = 10;
  localparam int unsigned SCALE_DIV_DEF  = 10;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 13;
  localparam int unsigned JERK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned WL_CFG_W   = 9;
  localparam int unsigned MEAN_W     = 32;
  localparam int unsigned DEV_W      = 33;

  // register reset values
  localparam int unsigned WINDOW_RESET = 50;
  localparam logic [31:0] SENS_RESET   = 32'd400;
  localparam logic [31:0] STILL_RESET  = 32'd0;
  localparam logic        VIB_RESET    = 1'b1;
  localparam logic        RING_RESET   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH  = 3'd0,
    REG_SENSITIVITY    = 3'd1,
    REG_STILL_LEVEL    = 3'd2,
    REG_VIBRATE_ENABLE = 3'd3,
    REG_RING_ENABLE    = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIVC,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV,
    ST_DEV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic jerk_mul;
    logic jerk_div;
    logic jerk_write;
    logic scan_start;
    logic scan_issue;
    logic div_start;
    logic div_step;
    logic dev_calc;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic issue_last;
    logic pipe_busy;
    logic div_last;
  } status_t;

endpackage

[hw/rtl/sjd_ctrl.sv]
// sjd_ctrl: sequencer for the stillness jolt detector
// drives the datapath commands and both handshakes; uses sjd_pkg
module sjd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sjd_pkg::status_t  status_i,
  output sjd_pkg::cmd_t     cmd_o
);
  import sjd_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.jerk_mul = 1'b1;
        state_d        = ST_DIVC;
      end
      ST_DIVC: begin
        cmd_o.jerk_div = 1'b1;
        state_d        = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.jerk_write = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd_o.dev_calc = 1'b1;
        state_d        = ST_OUT;
      end
      ST_OUT: begin
        // wait until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/sjd_datapath.sv]
// sjd_datapath: jerk lanes, jerk memory, window accumulator, divider, result
// registers and configuration registers; uses sjd_pkg, driven by sjd_ctrl
module sjd_datapath #(
  parameter int unsigned MAX_WINDOW = sjd_pkg::MAX_WINDOW_DEF,
  parameter int unsigned RATE_NUM   = sjd_pkg::RATE_NUM_DEF,
  parameter int unsigned SCALE_DIV  = sjd_pkg::SCALE_DIV_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sjd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sjd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_x_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_y_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_z_i,
  input  sjd_pkg::cmd_t                        cmd_i,
  output sjd_pkg::status_t                     status_o,
  output logic [sjd_pkg::MEAN_W-1:0]           mean_jolt_o,
  output logic signed [sjd_pkg::DEV_W-1:0]     jolt_deviation_o,
  output logic                                 warming_up_o,
  output logic                                 vibrate_alarm_o,
  output logic                                 ring_alarm_o
);
  import sjd_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_WINDOW);
  localparam int unsigned WL_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned WL_RESET =
    (WINDOW_RESET > MAX_WINDOW) ? MAX_WINDOW : WINDOW_RESET;
  // jerk magnitude before scaling and the reciprocal for SCALE_DIV
  localparam int unsigned DIFF_W  = SAMPLE_W + 1;
  localparam int unsigned P_W     = $clog2(8191 * RATE_NUM + 1);
  localparam int unsigned L_W     = $clog2(SCALE_DIV);
  localparam int unsigned K_SH    = P_W + L_W;
  localparam int unsigned R_W     = P_W + 2;
  localparam int unsigned MP_W    = P_W + R_W;
  localparam logic [63:0] RECIP   =
    ((64'd1 << K_SH) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV);
  // window sum and divider
  localparam int unsigned SQ_W    = 31;
  localparam int unsigned SUM_W   = 30 + $clog2(3 * MAX_WINDOW + 1);
  localparam int unsigned DCNT_W  = $clog2(SUM_W);
  localparam int unsigned MEM_W   = 3 * JERK_W;

  // configuration registers
  logic [WL_W-1:0]  wl_q;
  logic [31:0]      sens_q;
  logic [31:0]      still_q;
  logic             vib_en_q;
  logic             ring_en_q;
  logic [31:0]      wl_raw;
  logic [31:0]      wl_clamp;
  logic [WL_W-1:0]  wl_new;

  // window bookkeeping
  logic [IDX_W-1:0] pos_q;
  logic [WL_W-1:0]  pos_inc;
  logic             not_filled_q;
  logic             first_q;
  logic [WL_W-1:0]  fill_q;

  // per-item payload
  logic signed [SAMPLE_W-1:0] smp [3];
  logic [SAMPLE_W-1:0] prev_q [3];
  logic [DIFF_W-1:0]   diff_q [3];
  logic [DIFF_W-1:0]   diff_abs [3];
  logic [P_W-1:0]      prod_q [3];
  logic                sgn_q [3];
  logic [P_W-1:0]      quo_q [3];
  logic                sgn2_q [3];
  logic [MP_W-1:0]     scaled [3];
  logic [JERK_W-1:0]   jerk [3];
  logic [JERK_W-1:0]   q16 [3];
  logic [31:0]         lim [3];
  logic                warm_q;
  logic                skip_q;

  // jerk memory and scan pipeline
  logic [MEM_W-1:0]    jerk_mem [MAX_WINDOW];
  logic [MEM_W-1:0]    rdata_q;
  logic                rd_zero_q;
  logic                rd_vld_q;
  logic [WL_W-1:0]     scan_cnt_q;
  logic signed [JERK_W-1:0] rd_lane [3];
  logic signed [31:0]  sq_full [3];
  logic [SQ_W-1:0]     sq_q [3];
  logic                sq_vld_q;
  logic [31:0]         ent_q;
  logic                ent_vld_q;
  logic [SUM_W-1:0]    acc_q;

  // divider and result
  logic [SUM_W-1:0]    dq_q;
  logic [WL_W-1:0]     rem_q;
  logic [WL_W:0]       rem_sh;
  logic                rem_ge;
  logic [DCNT_W-1:0]   div_cnt_q;
  logic [MEAN_W-1:0]   mean_sat;
  logic [MEAN_W-1:0]   mean_q;
  logic [DEV_W-1:0]    dev_q;
  logic signed [DEV_W:0] dev_x;
  logic signed [DEV_W:0] sens_x;
  logic                is_still;

  assign smp[0] = accel_x_i;
  assign smp[1] = accel_y_i;
  assign smp[2] = accel_z_i;

  // window length write: zero reads as one, large values stop at the depth
  always_comb begin
    wl_raw = 32'(cfg_wdata_i[WL_CFG_W-1:0]);
    if (wl_raw == 32'd0) begin
      wl_clamp = 32'd1;
    end else if (wl_raw > 32'(MAX_WINDOW)) begin
      wl_clamp = 32'(MAX_WINDOW);
    end else begin
      wl_clamp = wl_raw;
    end
    wl_new  = WL_W'(wl_clamp);
    pos_inc = WL_W'(pos_q) + WL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q         <= WL_W'(WL_RESET);
      sens_q       <= SENS_RESET;
      still_q      <= STILL_RESET;
      vib_en_q     <= VIB_RESET;
      ring_en_q    <= RING_RESET;
      pos_q        <= '0;
      not_filled_q <= 1'b1;
      first_q      <= 1'b1;
      fill_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WINDOW_LENGTH: begin
            wl_q         <= wl_new;
            not_filled_q <= 1'b1;
            if (32'(pos_q) >= 32'(wl_new)) begin
              pos_q <= '0;
            end
          end
          REG_SENSITIVITY:    sens_q    <= cfg_wdata_i;
          REG_STILL_LEVEL:    still_q   <= cfg_wdata_i;
          REG_VIBRATE_ENABLE: vib_en_q  <= cfg_wdata_i[0];
          REG_RING_ENABLE:    ring_en_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        first_q <= 1'b0;
      end
      if (cmd_i.jerk_write) begin
        // written slots always form a prefix, so a fill count stands in for a clear
        if (pos_inc > fill_q) begin
          fill_q <= pos_inc;
        end
        if (pos_inc >= wl_q) begin
          pos_q        <= '0;
          not_filled_q <= 1'b0;
        end else begin
          pos_q <= IDX_W'(pos_inc);
        end
      end
    end
  end

  // jerk lanes: difference, magnitude times RATE_NUM, reciprocal divide, clip
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff_abs[k] = diff_q[k][DIFF_W-1] ? (DIFF_W'(0) - diff_q[k]) : diff_q[k];
      scaled[k]   = MP_W'(prod_q[k]) * MP_W'(RECIP);
      lim[k]      = sgn2_q[k] ? 32'd32768 : 32'd32767;
      q16[k]      = (32'(quo_q[k]) > lim[k]) ? JERK_W'(lim[k]) : JERK_W'(quo_q[k]);
      if (skip_q) begin
        jerk[k] = '0;
      end else begin
        jerk[k] = sgn2_q[k] ? (JERK_W'(0) - q16[k]) : q16[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      warm_q <= not_filled_q;
      skip_q <= first_q;
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= {smp[k][SAMPLE_W-1], smp[k]} - {prev_q[k][SAMPLE_W-1], prev_q[k]};
        prev_q[k] <= smp[k];
      end
    end
    if (cmd_i.jerk_mul) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= P_W'(32'(diff_abs[k][SAMPLE_W-1:0]) * 32'(RATE_NUM));
        sgn_q[k]  <= diff_q[k][DIFF_W-1];
      end
    end
    if (cmd_i.jerk_div) begin
      for (int k = 0; k < 3; k++) begin
        quo_q[k]  <= P_W'(scaled[k] >> K_SH);
        sgn2_q[k] <= sgn_q[k];
      end
    end
  end

  // jerk memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.jerk_write) begin
      jerk_mem[pos_q] <= {jerk[0], jerk[1], jerk[2]};
    end
    if (cmd_i.scan_issue) begin
      rdata_q <= jerk_mem[scan_cnt_q[IDX_W-1:0]];
    end
  end

  assign rd_lane[0] = rd_zero_q ? '0 : signed'(rdata_q[3*JERK_W-1:2*JERK_W]);
  assign rd_lane[1] = rd_zero_q ? '0 : signed'(rdata_q[2*JERK_W-1:JERK_W]);
  assign rd_lane[2] = rd_zero_q ? '0 : signed'(rdata_q[JERK_W-1:0]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_full[k] = 32'(rd_lane[k]) * 32'(rd_lane[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q  <= 1'b0;
      sq_vld_q  <= 1'b0;
      ent_vld_q <= 1'b0;
    end else begin
      rd_vld_q  <= cmd_i.scan_issue;
      sq_vld_q  <= rd_vld_q;
      ent_vld_q <= sq_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      scan_cnt_q <= '0;
    end else if (cmd_i.scan_issue) begin
      scan_cnt_q <= scan_cnt_q + WL_W'(1);
    end
    if (cmd_i.scan_issue) begin
      rd_zero_q <= (scan_cnt_q >= fill_q);
    end
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= sq_full[k][SQ_W-1:0];
    end
    ent_q <= 32'(sq_q[0]) + 32'(sq_q[1]) + 32'(sq_q[2]);
    if (cmd_i.scan_start) begin
      acc_q <= '0;
    end else if (ent_vld_q) begin
      acc_q <= acc_q + SUM_W'(ent_q);
    end
  end

  // restoring divider: one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, dq_q[SUM_W-1]};
    rem_ge = (rem_sh >= {1'b0, wl_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q      <= acc_q;
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dq_q      <= {dq_q[SUM_W-2:0], rem_ge};
      rem_q     <= rem_ge ? WL_W'(rem_sh - {1'b0, wl_q}) : rem_sh[WL_W-1:0];
      div_cnt_q <= div_cnt_q + DCNT_W'(1);
    end
  end

  // mean saturation, deviation and the still window
  always_comb begin
    mean_sat = (|dq_q[SUM_W-1:MEAN_W]) ? '1 : dq_q[MEAN_W-1:0];
    dev_x    = signed'({dev_q[DEV_W-1], dev_q});
    sens_x   = signed'({2'b00, sens_q});
    is_still = !warm_q && (dev_x < sens_x) && (dev_x > -sens_x);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dev_calc) begin
      mean_q <= mean_sat;
      dev_q  <= {1'b0, mean_sat} - {1'b0, still_q};
    end
    if (cmd_i.out_load) begin
      mean_jolt_o      <= mean_q;
      jolt_deviation_o <= signed'(dev_q);
      warming_up_o     <= warm_q;
      vibrate_alarm_o  <= is_still && vib_en_q;
      ring_alarm_o     <= is_still && ring_en_q;
    end
  end

  assign status_o.issue_last = (scan_cnt_q == (wl_q - WL_W'(1)));
  assign status_o.pipe_busy  = rd_vld_q || sq_vld_q || ent_vld_q;
  assign status_o.div_last   = (div_cnt_q == DCNT_W'(SUM_W - 1));

endmodule

[hw/rtl/stillness_jolt_detector_core.sv]
// stillness_jolt_detector_core: top level of the stillness jolt detector
// one beat in gives one beat out: a full walk of the jerk window each sample
// a sample passes the jerk lanes, the window walk, the divider and the deviation step before its result load;
//   SUM_W = 30 + clog2(3*MAX_WINDOW+1), 40 at the default depth
// a new sample is taken only after the result of the last one has been loaded
// reset: async active low; no clearing pass, a fill count makes unwritten slots read zero
module stillness_jolt_detector_core #(
  parameter int unsigned MAX_WINDOW = sjd_pkg::MAX_WINDOW_DEF,
  parameter int unsigned RATE_NUM   = sjd_pkg::RATE_NUM_DEF,
  parameter int unsigned SCALE_DIV  = sjd_pkg::SCALE_DIV_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write port
  input  logic                                 cfg_we_i,
  input  logic [sjd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sjd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  // sample beat
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_x_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_y_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_z_i,
  // result beat
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sjd_pkg::MEAN_W-1:0]           mean_jolt_o,
  output logic signed [sjd_pkg::DEV_W-1:0]     jolt_deviation_o,
  output logic                                 warming_up_o,
  output logic                                 vibrate_alarm_o,
  output logic                                 ring_alarm_o
);
  import sjd_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: takes a beat in idle, steps jerk, scan, divide and result phases
  sjd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath: jerk lanes, jerk memory, window sum, divider and result register
  sjd_datapath #(
    .MAX_WINDOW (MAX_WINDOW),
    .RATE_NUM   (RATE_NUM),
    .SCALE_DIV  (SCALE_DIV)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .accel_x_i        (accel_x_i),
    .accel_y_i        (accel_y_i),
    .accel_z_i        (accel_z_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .mean_jolt_o      (mean_jolt_o),
    .jolt_deviation_o (jolt_deviation_o),
    .warming_up_o     (warming_up_o),
    .vibrate_alarm_o  (vibrate_alarm_o),
    .ring_alarm_o     (ring_alarm_o)
  );

  // an accepted beat keeps the input closed until its result is loaded
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  // no alarm while the window is still warming up
  a_no_alarm_warm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (vibrate_alarm_o || ring_alarm_o)) |-> !warming_up_o)
    else $error("alarm raised during warm-up");

  // a new result only appears after a result load
  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(cmd.out_load))
    else $error("result valid without a load");

  // scan and divider never run together
  a_phase_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.scan_issue && (cmd.div_step || cmd.div_start)))
    else $error("window scan overlaps the divider");

endmodule

[sim/sjd_jolt_checker.sv]
// sjd_jolt_checker: watches the sample and result beats of the jolt detector,
// keeps its own copy of the window state and compares every result beat
// depends on sjd_pkg for widths, defaults and register indexes
module sjd_jolt_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [sjd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [sjd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_x_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_y_i,
  input  logic signed [sjd_pkg::SAMPLE_W-1:0]  accel_z_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [sjd_pkg::MEAN_W-1:0]           mean_jolt_i,
  input  logic signed [sjd_pkg::DEV_W-1:0]     jolt_deviation_i,
  input  logic                                 warming_up_i,
  input  logic                                 vibrate_alarm_i,
  input  logic                                 ring_alarm_i,
  output int unsigned                          error_count_o,
  output int unsigned                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sjd_pkg::*;

  localparam longint JERK_HI = (longint'(1) << (JERK_W - 1)) - 1;
  localparam longint JERK_LO = -JERK_HI - 1;

  typedef struct packed {
    logic [MEAN_W-1:0]       mean;
    logic signed [DEV_W-1:0] dev;
    logic                    warm;
    logic                    vib;
    logic                    ring;
  } jolt_result_t;

  // window state
  logic signed [JERK_W-1:0]   jerk_x [MAX_WINDOW_DEF];
  logic signed [JERK_W-1:0]   jerk_y [MAX_WINDOW_DEF];
  logic signed [JERK_W-1:0]   jerk_z [MAX_WINDOW_DEF];
  logic signed [SAMPLE_W-1:0] prev_x, prev_y, prev_z;
  int unsigned                wr_pos;
  bit                         not_filled;
  bit                         first_sample;

  // register copies
  int unsigned                win_len;
  logic [31:0]                sens;
  logic [31:0]                still_lvl;
  logic                       vib_en;
  logic                       ring_en;

  jolt_result_t               expected_jolts[$];
  int unsigned                errs = 0;
  int unsigned                result_count = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns jolt check: %s", $realtime, msg);
    errs++;
  endtask

  function automatic logic signed [JERK_W-1:0] jerk_of_axis(input longint now_s,
                                                            input longint before_s);
    longint j;
    j = (now_s - before_s) * longint'(RATE_NUM_DEF) / longint'(SCALE_DIV_DEF);
    if (j > JERK_HI) j = JERK_HI;
    if (j < JERK_LO) j = JERK_LO;
    return j[JERK_W-1:0];
  endfunction

  function automatic jolt_result_t predict_jolt(input logic signed [SAMPLE_W-1:0] x,
                                                input logic signed [SAMPLE_W-1:0] y,
                                                input logic signed [SAMPLE_W-1:0] z);
    jolt_result_t      r;
    longint unsigned   total;
    longint unsigned   avg;
    longint unsigned   mag;
    longint            dev;
    longint            a, b, c;
    int unsigned       pos;
    int unsigned       i;
    bit                warm;
    bit                still;
    pos  = wr_pos;
    warm = not_filled;
    if (pos >= MAX_WINDOW_DEF) pos = 0;
    // first sample only primes the previous-sample register
    if (!first_sample) begin
      jerk_x[pos] = jerk_of_axis(x, prev_x);
      jerk_y[pos] = jerk_of_axis(y, prev_y);
      jerk_z[pos] = jerk_of_axis(z, prev_z);
    end
    first_sample = 1'b0;
    prev_x = x;
    prev_y = y;
    prev_z = z;
    total = 0;
    for (i = 0; i < win_len; i++) begin
      a = jerk_x[i];
      b = jerk_y[i];
      c = jerk_z[i];
      total += a * a + b * b + c * c;
    end
    avg = total / win_len;
    if (avg > 64'hFFFF_FFFF) avg = 64'hFFFF_FFFF;
    dev   = longint'(avg) - longint'(still_lvl);
    mag   = (dev < 0) ? -dev : dev;
    still = (mag < sens) && !warm;
    pos++;
    if (pos >= win_len) begin
      pos        = 0;
      not_filled = 1'b0;
    end
    wr_pos = pos;
    r.mean = avg[MEAN_W-1:0];
    r.dev  = dev[DEV_W-1:0];
    r.warm = warm;
    r.vib  = still && vib_en;
    r.ring = still && ring_en;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    jolt_result_t want;
    int unsigned  k;
    logic [WL_CFG_W-1:0] wl_raw;
    if (!rst_ni) begin
      for (k = 0; k < MAX_WINDOW_DEF; k++) begin
        jerk_x[k] = '0;
        jerk_y[k] = '0;
        jerk_z[k] = '0;
      end
      prev_x       = '0;
      prev_y       = '0;
      prev_z       = '0;
      wr_pos       = 0;
      not_filled   = 1'b1;
      first_sample = 1'b1;
      win_len      = WINDOW_RESET;
      sens         = SENS_RESET;
      still_lvl    = STILL_RESET;
      vib_en       = VIB_RESET;
      ring_en      = RING_RESET;
      expected_jolts.delete();
      pending_o     <= 0;
      error_count_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_WINDOW_LENGTH: begin
            wl_raw = cfg_wdata_i[WL_CFG_W-1:0];
            if (wl_raw == 0) win_len = 1;
            else if (wl_raw > MAX_WINDOW_DEF) win_len = MAX_WINDOW_DEF;
            else win_len = wl_raw;
            not_filled = 1'b1;
            if (wr_pos >= win_len) wr_pos = 0;
          end
          REG_SENSITIVITY:    sens      = cfg_wdata_i;
          REG_STILL_LEVEL:    still_lvl = cfg_wdata_i;
          REG_VIBRATE_ENABLE: vib_en    = cfg_wdata_i[0];
          REG_RING_ENABLE:    ring_en   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_jolts.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with no sample waiting", result_count));
        end else begin
          want = expected_jolts.pop_front();
          if (mean_jolt_i !== want.mean)
            report_mismatch($sformatf("result %0d mean_jolt %0d, want %0d",
                                      result_count, mean_jolt_i, want.mean));
          if (jolt_deviation_i !== want.dev)
            report_mismatch($sformatf("result %0d jolt_deviation %0d, want %0d",
                                      result_count, jolt_deviation_i, want.dev));
          if (warming_up_i !== want.warm)
            report_mismatch($sformatf("result %0d warming_up %b, want %b",
                                      result_count, warming_up_i, want.warm));
          if (vibrate_alarm_i !== want.vib)
            report_mismatch($sformatf("result %0d vibrate_alarm %b, want %b",
                                      result_count, vibrate_alarm_i, want.vib));
          if (ring_alarm_i !== want.ring)
            report_mismatch($sformatf("result %0d ring_alarm %b, want %b",
                                      result_count, ring_alarm_i, want.ring));
        end
        result_count++;
      end
      if (in_valid_i && in_ready_i)
        expected_jolts.push_back(predict_jolt(accel_x_i, accel_y_i, accel_z_i));
      pending_o     <= expected_jolts.size();
      error_count_o <= errs;
    end
  end

endmodule

[sim/stillness_jolt_detector_core_test.sv]
// stillness_jolt_detector_core_test: stimulus and verdict for the jolt detector
// drives sample beats and register writes; prediction lives in sjd_jolt_checker
// depends on sjd_pkg, stillness_jolt_detector_core and sjd_jolt_checker
module stillness_jolt_detector_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sjd_pkg::*;

  localparam time CLK_HALF     = 4ns;
  localparam int  RESET_CYCLES = 11;
  // slowest item: full 256 window walk plus the divider and control steps, plus stalls
  localparam int  TAIL_CYCLES  = 400;
  localparam int  CYCLE_LIMIT  = 3_000_000;
  localparam int  RAND_PHASES  = 13;
  localparam int  SAMPLE_MAX   = (1 << (SAMPLE_W - 1)) - 1;
  localparam int  SAMPLE_MIN   = -SAMPLE_MAX - 1;
  // indexes past the last register, the block must ignore them
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_UNUSED = CFG_IDX_W'(REG_RING_ENABLE + 1);

  typedef enum {MOTION_STILL, MOTION_WALK, MOTION_SHAKE} motion_e;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] accel_x = '0;
  logic signed [SAMPLE_W-1:0] accel_y = '0;
  logic signed [SAMPLE_W-1:0] accel_z = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [MEAN_W-1:0]          mean_jolt;
  logic signed [DEV_W-1:0]    jolt_deviation;
  logic                       warming_up;
  logic                       vibrate_alarm;
  logic                       ring_alarm;
  int unsigned                error_count;
  int unsigned                pending_jolts;

  int                         sender_idle_pct = 0;
  int                         receiver_idle_pct = 0;
  int                         cycle_count;
  // current position of the simulated wearer
  int                         pos_x = 0, pos_y = 0, pos_z = 0;

  always #(CLK_HALF) clk = ~clk;

  stillness_jolt_detector_core u_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .accel_x_i        (accel_x),
    .accel_y_i        (accel_y),
    .accel_z_i        (accel_z),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .mean_jolt_o      (mean_jolt),
    .jolt_deviation_o (jolt_deviation),
    .warming_up_o     (warming_up),
    .vibrate_alarm_o  (vibrate_alarm),
    .ring_alarm_o     (ring_alarm)
  );

  sjd_jolt_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .accel_x_i        (accel_x),
    .accel_y_i        (accel_y),
    .accel_z_i        (accel_z),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .mean_jolt_i      (mean_jolt),
    .jolt_deviation_i (jolt_deviation),
    .warming_up_i     (warming_up),
    .vibrate_alarm_i  (vibrate_alarm),
    .ring_alarm_i     (ring_alarm),
    .error_count_o    (error_count),
    .pending_o        (pending_jolts)
  );

  // result side stalls at random, one decision per cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // hard stop if the block hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int clamp_sample(input int v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // one sample beat; valid stays up across back-to-back beats
  task automatic send_sample(input int x, input int y, input int z);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    accel_x  <= x[SAMPLE_W-1:0];
    accel_y  <= y[SAMPLE_W-1:0];
    accel_z  <= z[SAMPLE_W-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // drop valid and wait until every sample beat has its result
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_jolts != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // only while idle: drain first, then write the whole register set
  task automatic reconfigure(input logic [31:0] wl, input logic [31:0] sens,
                             input logic [31:0] lvl, input logic vib, input logic ring);
    wait_drained();
    write_reg(CFG_IDX_W'(REG_INDEX_UNUSED +
                         $urandom_range((1 << CFG_IDX_W) - 1 - REG_INDEX_UNUSED)),
              $urandom);
    write_reg(REG_SENSITIVITY, sens);
    write_reg(REG_STILL_LEVEL, lvl);
    write_reg(REG_VIBRATE_ENABLE, {31'($urandom_range(1 << 30)), vib});
    write_reg(REG_RING_ENABLE, {31'($urandom_range(1 << 30)), ring});
    write_reg(REG_WINDOW_LENGTH, wl);
    cfg_we <= 1'b0;
  endtask

  // stretches of stillness, walking and shaking with random content
  task automatic send_motion(input int n_items);
    motion_e mode;
    int      left;
    int      amp;
    int      r;
    left = 0;
    mode = MOTION_STILL;
    repeat (n_items) begin
      if (left == 0) begin
        r    = $urandom_range(99);
        mode = (r < 55) ? MOTION_STILL : (r < 85) ? MOTION_WALK : MOTION_SHAKE;
        left = $urandom_range(1, 40);
      end
      left--;
      if (mode == MOTION_SHAKE) begin
        if ($urandom_range(7) == 0) begin
          pos_x = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
          pos_y = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
          pos_z = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
        end else begin
          pos_x = int'($urandom_range(2 * SAMPLE_MAX + 1)) + SAMPLE_MIN;
          pos_y = int'($urandom_range(2 * SAMPLE_MAX + 1)) + SAMPLE_MIN;
          pos_z = int'($urandom_range(2 * SAMPLE_MAX + 1)) + SAMPLE_MIN;
        end
      end else begin
        amp   = (mode == MOTION_STILL) ? 2 : 60;
        pos_x = clamp_sample(pos_x + int'($urandom_range(2 * amp)) - amp);
        pos_y = clamp_sample(pos_y + int'($urandom_range(2 * amp)) - amp);
        pos_z = clamp_sample(pos_z + int'($urandom_range(2 * amp)) - amp);
      end
      send_sample(pos_x, pos_y, pos_z);
    end
  endtask

  initial begin
    int          phase;
    int          n_items;
    logic [31:0] wl;
    logic [31:0] sens;
    logic [31:0] lvl;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: first sample primes only, then full-scale swings
    send_sample(0, 0, 0);
    send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, 0);
    send_sample(1, -1, 0);
    send_sample(0, 0, 0);

    // window of zero taken as one, shrink wraps the write position, widest threshold
    reconfigure(32'd0, 32'hFFFF_FFFF, 32'd0, 1'b1, 1'b1);
    send_sample(5, 5, 5);
    send_sample(5, 5, 5);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);

    // oversized window clamps to the full depth, stale entries count again
    reconfigure(32'h0000_01FF, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b1);
    send_sample(0, 0, 0);
    send_sample(0, 0, 0);
    send_sample(100, -100, 7);
    send_sample(100, -100, 7);

    // short window fills quickly, vibrate only
    reconfigure(32'd2, SENS_RESET, STILL_RESET, 1'b1, 1'b0);
    send_sample(-3, 2, 1);
    send_sample(-3, 2, 1);
    send_sample(-3, 2, 1);
    send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
    send_sample(-3, 2, 1);

    for (phase = 0; phase < RAND_PHASES; phase++) begin
      n_items = 125;
      // mostly short windows, two long phases that fill the full depth
      if (phase == 2) begin
        wl      = MAX_WINDOW_DEF;
        n_items = 300;
      end else if (phase == 7) begin
        wl      = $urandom | 32'h1FF;
        n_items = 300;
      end else if ($urandom_range(9) == 0) begin
        wl = $urandom;
      end else begin
        wl = $urandom_range(1, 24);
      end
      case ($urandom_range(5))
        0:       sens = 32'd0;
        1:       sens = 32'hFFFF_FFFF;
        2:       sens = $urandom;
        default: sens = $urandom_range(20, 3000);
      endcase
      case ($urandom_range(5))
        0:       lvl = 32'hFFFF_FFFF;
        1:       lvl = $urandom;
        default: lvl = $urandom_range(0, 200);
      endcase
      reconfigure(wl, sens, lvl, 1'($urandom_range(1)), 1'($urandom_range(1)));
      // receiver idles more first, then the sender, then neither
      if (phase < 5) begin
        sender_idle_pct   = 29;
        receiver_idle_pct = 60;
      end else if (phase < 10) begin
        sender_idle_pct   = 60;
        receiver_idle_pct = 29;
      end else begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      send_motion(n_items);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
